// ===== rtl/core/oal_pkg.sv =====
// ----------------------------------------------------------------------------
// oal_pkg
// Shared constants, codes and types for the ordered array list engine.
// ----------------------------------------------------------------------------
package oal_pkg;

    // Storage geometry
    localparam int LIST_CAPACITY = 32;
    localparam int KEY_BITS      = 64;
    localparam int PAYLOAD_BITS  = 64;

    // Port field widths
    localparam int OPCODE_W   = 3;
    localparam int POSITION_W = 5;
    localparam int FIELD_W    = 64;
    localparam int STATUS_W   = 3;
    localparam int FOUND_W    = 5;
    localparam int COUNT_W    = 6;

    // Derived internal widths
    localparam int IDX_W     = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam int CNT_W     = $clog2(LIST_CAPACITY + 1);
    localparam int CMP_W     = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam int CNT_OUT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam int S_DATA_W = 8 * ((OPCODE_W + POSITION_W + 2 * FIELD_W + 7) / 8);
    localparam int M_DATA_W =
        8 * ((STATUS_W + FOUND_W + 2 * FIELD_W + COUNT_W + 2 + 7) / 8);

    typedef enum logic [OPCODE_W-1:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_AT    = 3'd1,
        OP_INS_LAST  = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_AT    = 3'd4,
        OP_DEL_LAST  = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_NOP       = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADIDX   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic [IDX_W-1:0]        pos;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } cell_cmd_t;

endpackage

// ===== rtl/core/oal_cell.sv =====
// ----------------------------------------------------------------------------
// oal_cell
// One list slot: holds a key and payload, shifts with its neighbors on
// insert and delete, and compares its key against the search key.
// ----------------------------------------------------------------------------
module oal_cell import oal_pkg::*; (
    input  logic                    aclk,
    input  logic [IDX_W-1:0]        cell_idx,
    input  cell_cmd_t               cmd,
    input  logic                    cell_live,
    input  logic [KEY_BITS-1:0]     left_key,
    input  logic [PAYLOAD_BITS-1:0] left_payload,
    input  logic [KEY_BITS-1:0]     right_key,
    input  logic [PAYLOAD_BITS-1:0] right_payload,
    output logic [KEY_BITS-1:0]     cell_key,
    output logic [PAYLOAD_BITS-1:0] cell_payload,
    output logic                    cell_match
);

    logic [KEY_BITS-1:0]     key_reg,     key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;

    always_comb begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (cmd.ins) begin
            if (cell_idx > cmd.pos) begin
                // shift up: take the entry from the lower neighbor
                key_next     = left_key;
                payload_next = left_payload;
            end else if (cell_idx == cmd.pos) begin
                key_next     = cmd.key;
                payload_next = cmd.payload;
            end
        end else if (cmd.del) begin
            if (cell_idx >= cmd.pos) begin
                // close the gap: take the entry from the upper neighbor
                key_next     = right_key;
                payload_next = right_payload;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign cell_key     = key_reg;
    assign cell_payload = payload_reg;
    assign cell_match   = cell_live && (key_reg == cmd.key);

endmodule

// ===== rtl/core/ordered_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Dense ordered list of keyed entries with insert, delete and search.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream channel, one per transaction; tdata
//   carries opcode, position, entry_key and entry_payload from bit 0 up.
//   Each request yields exactly one result transaction on the m_ channel:
//   status, found_index, removed_key, removed_payload, entry_count,
//   list_empty and list_full from bit 0 up.
//   Storage is a chain of LIST_CAPACITY cells. Every cell shifts, loads or
//   holds in the same cycle, and all cells compare their key with the
//   request key at once, so a request is handled by one parallel update.
//   The result is registered and presented in the cycle after the request
//   is accepted. Throughput: one request per cycle while the receiver
//   keeps up, set by the single parallel update of the cell chain.
//   Reset (aresetn low, synchronous) empties the list and drops any
//   pending result; cell contents are left as they are and are never read
//   before being written.
//   When the receiver stalls, the result register holds its value and
//   s_tready drops, so no new request is accepted until the result leaves.
//   Full, empty and bad-index requests leave the list unchanged and report
//   the condition in status.
// ----------------------------------------------------------------------------
module ordered_array_list_engine import oal_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // opcode[2:0], position[7:3], entry_key[71:8], entry_payload[135:72]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status[2:0], found_index[7:3], removed_key[71:8],
    // removed_payload[135:72], entry_count[141:136], list_empty[142],
    // list_full[143]
    output logic [M_DATA_W-1:0] m_tdata
);

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    opcode_t                 in_op;
    logic [POSITION_W-1:0]   in_pos;
    logic [KEY_BITS-1:0]     in_key;
    logic [PAYLOAD_BITS-1:0] in_payload;

    assign in_op      = opcode_t'(s_tdata[OPCODE_W-1:0]);
    assign in_pos     = s_tdata[OPCODE_W +: POSITION_W];
    assign in_key     = s_tdata[OPCODE_W + POSITION_W +: KEY_BITS];
    assign in_payload = s_tdata[OPCODE_W + POSITION_W + FIELD_W +: PAYLOAD_BITS];

    logic accept;
    logic out_valid_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // List count
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] count_reg, count_next;
    logic             is_full, is_empty;
    logic [CMP_W-1:0] pos_ext, cnt_ext;

    assign is_full  = (count_reg == CNT_W'(LIST_CAPACITY));
    assign is_empty = (count_reg == '0);
    assign pos_ext  = CMP_W'(in_pos);
    assign cnt_ext  = CMP_W'(count_reg);

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    cell_cmd_t               cmd;
    logic [KEY_BITS-1:0]     cell_key     [LIST_CAPACITY];
    logic [PAYLOAD_BITS-1:0] cell_payload [LIST_CAPACITY];
    logic [LIST_CAPACITY-1:0] match_vec;

    for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0]     lk, rk;
        logic [PAYLOAD_BITS-1:0] lp, rp;

        if (g == 0) begin : g_first
            assign lk = cmd.key;
            assign lp = cmd.payload;
        end else begin : g_mid_lo
            assign lk = cell_key[g-1];
            assign lp = cell_payload[g-1];
        end

        if (g == LIST_CAPACITY - 1) begin : g_last
            assign rk = '0;
            assign rp = '0;
        end else begin : g_mid_hi
            assign rk = cell_key[g+1];
            assign rp = cell_payload[g+1];
        end

        oal_cell u_cell (
            .aclk          (aclk),
            .cell_idx      (IDX_W'(g)),
            .cmd           (cmd),
            .cell_live     (CNT_W'(g) < count_reg),
            .left_key      (lk),
            .left_payload  (lp),
            .right_key     (rk),
            .right_payload (rp),
            .cell_key      (cell_key[g]),
            .cell_payload  (cell_payload[g]),
            .cell_match    (match_vec[g])
        );
    end

    // Lowest matching index
    logic [IDX_W-1:0] match_idx;

    always_comb begin
        match_idx = '0;
        for (int i = LIST_CAPACITY - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                match_idx = IDX_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    status_t          st;
    logic             do_ins, do_del, do_found;
    logic [IDX_W-1:0] op_pos;

    always_comb begin
        st       = ST_OK;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        do_found = 1'b0;
        op_pos   = '0;
        case (in_op)
            OP_INS_FIRST: begin
                if (is_full) st = ST_FULL;
                else         do_ins = 1'b1;
            end
            OP_INS_AT: begin
                op_pos = IDX_W'(pos_ext);
                if (is_full)               st = ST_FULL;
                else if (pos_ext > cnt_ext) st = ST_BADIDX;
                else                        do_ins = 1'b1;
            end
            OP_INS_LAST: begin
                op_pos = IDX_W'(count_reg);
                if (is_full) st = ST_FULL;
                else         do_ins = 1'b1;
            end
            OP_DEL_FIRST: begin
                if (is_empty) st = ST_EMPTY;
                else          do_del = 1'b1;
            end
            OP_DEL_AT: begin
                op_pos = IDX_W'(pos_ext);
                if (is_empty)                st = ST_EMPTY;
                else if (pos_ext >= cnt_ext) st = ST_BADIDX;
                else                         do_del = 1'b1;
            end
            OP_DEL_LAST: begin
                op_pos = IDX_W'(count_reg - CNT_W'(1));
                if (is_empty) st = ST_EMPTY;
                else          do_del = 1'b1;
            end
            OP_SEARCH: begin
                if (|match_vec) do_found = 1'b1;
                else            st = ST_NOTFOUND;
            end
            default: begin
            end
        endcase
    end

    // Broadcast to the chain only on an accepted, legal modification
    always_comb begin
        cmd.ins     = accept && do_ins;
        cmd.del     = accept && do_del;
        cmd.pos     = op_pos;
        cmd.key     = in_key;
        cmd.payload = in_payload;
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.ins)      count_next = count_reg + CNT_W'(1);
        else if (cmd.del) count_next = count_reg - CNT_W'(1);
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    status_t                 status_reg;
    logic [FOUND_W-1:0]      found_reg;
    logic [FIELD_W-1:0]      rm_key_reg, rm_payload_reg;
    logic [COUNT_W-1:0]      cnt_out_reg;
    logic                    empty_reg, full_reg;
    logic [CMP_W-1:0]        found_ext;
    logic [CNT_OUT_W-1:0]    cnt_wide;

    assign found_ext = CMP_W'(match_idx);
    assign cnt_wide  = CNT_OUT_W'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the payload while the receiver stalls; load on each transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg     <= st;
            found_reg      <= do_found ? found_ext[FOUND_W-1:0] : '0;
            rm_key_reg     <= do_del ? FIELD_W'(cell_key[op_pos]) : '0;
            rm_payload_reg <= do_del ? FIELD_W'(cell_payload[op_pos]) : '0;
            cnt_out_reg    <= cnt_wide[COUNT_W-1:0];
            empty_reg      <= (count_next == '0);
            full_reg       <= (count_next == CNT_W'(LIST_CAPACITY));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({full_reg, empty_reg, cnt_out_reg, rm_payload_reg,
                                 rm_key_reg, found_reg, status_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LIST_CAPACITY))
        else $error("entry count above capacity");

    a_ins_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_search_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == OP_SEARCH) |=> $stable(count_reg))
        else $error("search changed the entry count");

    a_flags_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (st == ST_FULL || st == ST_EMPTY || st == ST_BADIDX))
            |-> (!cmd.ins && !cmd.del))
        else $error("rejected request modified the list");

endmodule
